FILE: hdl/kfd_pkg.sv
// Package for the KISS frame decoder: byte codes, phase codes and the result record.
// Depends on nothing; all other files of the decoder use it by scoped names.

package kfd_pkg;

  // KISS special bytes.
  localparam logic [7:0] Fend  = 8'hC0;
  localparam logic [7:0] Fesc  = 8'hDB;
  localparam logic [7:0] Tfend = 8'hDC;
  localparam logic [7:0] Tfesc = 8'hDD;

  // Decoder phase codes.
  localparam logic [2:0] PhOpen  = 3'd0;
  localparam logic [2:0] PhType  = 3'd1;
  localparam logic [2:0] PhBody  = 3'd2;
  localparam logic [2:0] PhEsc   = 3'd3;
  localparam logic [2:0] PhFault = 3'd4;

  // Result kinds and frame status codes.
  localparam logic KindBody   = 1'b0;
  localparam logic KindStatus = 1'b1;
  localparam logic StatusOk   = 1'b0;
  localparam logic StatusBad  = 1'b1;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);

  // One result item.
  typedef struct packed {
    logic       kind;
    logic [7:0] body;
    logic [7:0] ftype;
    logic       status;
  } res_t;

endpackage

FILE: hdl/kfd_front.sv
// Front part of the KISS frame decoder: framing state and byte classification.
// Depends on kfd_pkg; feeds kfd_queue with at most one result per accepted byte.

module kfd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  output logic          res_valid_o,
  output kfd_pkg::res_t res_o
);

  logic [2:0] phase_q, phase_d;
  logic       seen_q, seen_d;
  logic [7:0] type_q, type_d;
  logic       emit;
  logic [7:0] emit_byte;
  logic       frame_ok;

  // Next state and result selection for one byte.
  always_comb begin
    phase_d   = phase_q;
    seen_d    = seen_q;
    type_d    = type_q;
    emit      = 1'b0;
    emit_byte = data_byte_i;
    frame_ok  = (phase_q == kfd_pkg::PhBody) && seen_q && (data_byte_i == kfd_pkg::Fend);
    if (last_byte_i) begin
      phase_d = kfd_pkg::PhOpen;
      seen_d  = 1'b0;
      type_d  = 8'h00;
    end else begin
      unique case (phase_q)
        kfd_pkg::PhOpen: begin
          phase_d = (data_byte_i == kfd_pkg::Fend) ? kfd_pkg::PhType : kfd_pkg::PhFault;
        end
        kfd_pkg::PhType: begin
          type_d  = data_byte_i;
          seen_d  = 1'b0;
          phase_d = kfd_pkg::PhBody;
        end
        kfd_pkg::PhBody: begin
          if (data_byte_i == kfd_pkg::Fend) begin
            phase_d = kfd_pkg::PhFault;
          end else if (data_byte_i == kfd_pkg::Fesc) begin
            seen_d  = 1'b1;
            phase_d = kfd_pkg::PhEsc;
          end else begin
            seen_d = 1'b1;
            emit   = 1'b1;
          end
        end
        kfd_pkg::PhEsc: begin
          if (data_byte_i == kfd_pkg::Tfend) begin
            emit      = 1'b1;
            emit_byte = kfd_pkg::Fend;
            phase_d   = kfd_pkg::PhBody;
          end else if (data_byte_i == kfd_pkg::Tfesc) begin
            emit      = 1'b1;
            emit_byte = kfd_pkg::Fesc;
            phase_d   = kfd_pkg::PhBody;
          end else begin
            phase_d = kfd_pkg::PhFault;
          end
        end
        default: begin
          phase_d = kfd_pkg::PhFault;
        end
      endcase
    end
  end

  // Result record toward the queue.
  always_comb begin
    res_valid_o = accept_i && (last_byte_i || emit);
    res_o.ftype = type_q;
    if (last_byte_i) begin
      res_o.kind   = kfd_pkg::KindStatus;
      res_o.body   = 8'h00;
      res_o.status = frame_ok ? kfd_pkg::StatusOk : kfd_pkg::StatusBad;
    end else begin
      res_o.kind   = kfd_pkg::KindBody;
      res_o.body   = emit_byte;
      res_o.status = kfd_pkg::StatusOk;
    end
  end

  // Framing state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= kfd_pkg::PhOpen;
      seen_q  <= 1'b0;
      type_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
      type_q  <= type_d;
    end
  end

`ifndef ASSERT_OFF
  // The end of a buffer always returns the decoder to the opening phase.
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> (phase_q == kfd_pkg::PhOpen) && !seen_q)
    else $error("phase not cleared after last byte");

  // Body bytes come only out of the body or escape phases.
  a_body_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && (res_o.kind == kfd_pkg::KindBody) |->
      (phase_q == kfd_pkg::PhBody) || (phase_q == kfd_pkg::PhEsc))
    else $error("body byte emitted outside the body");
`endif

endmodule

FILE: hdl/kfd_queue.sv
// Short result queue between the front and back parts of the KISS frame decoder.
// Depends on kfd_pkg for the result record and the queue depth.

module kfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  kfd_pkg::res_t wdata_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          valid_o,
  output kfd_pkg::res_t rdata_o
);

  kfd_pkg::res_t             slots_q [kfd_pkg::QDepth];
  logic [kfd_pkg::QAw-1:0]   wr_ptr_q, rd_ptr_q;
  logic [kfd_pkg::QAw:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == (kfd_pkg::QAw+1)'(kfd_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = slots_q[rd_ptr_q];

  // Occupancy update.
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  // Pointers and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef ASSERT_OFF
  // Occupancy never exceeds the depth.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (kfd_pkg::QAw+1)'(kfd_pkg::QDepth))
    else $error("queue count out of range");

  // No pop from an empty queue and no push into a full one.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o) && !(push_i && full_o))
    else $error("queue overflow or underflow");
`endif

endmodule

FILE: hdl/kfd_back.sv
// Back part of the KISS frame decoder: output register that presents the oldest result.
// Depends on kfd_pkg for the result record; drains kfd_queue.

module kfd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  kfd_pkg::res_t q_data_i,
  output logic          q_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output kfd_pkg::res_t res_o
);

  logic          out_valid_q;
  kfd_pkg::res_t out_q;

  // Refill the output register when it is free or being taken.
  assign q_pop_o = q_valid_i && (!out_valid_q || pop_i);
  assign empty_o = !out_valid_q;
  assign res_o   = out_q;

  // Valid flag of the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_data_i;
    end
  end

`ifndef ASSERT_OFF
  // A held result is not replaced unless it was taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pop_i |=> out_valid_q && (out_q == $past(out_q)))
    else $error("output result lost");
`endif

endmodule

FILE: hdl/kiss_frame_decoder.sv
// KISS frame decoder top level: front classifier, result queue and output register.
// Accepts one byte per cycle while full is low; each result goes through the queue
// and then the output register, and is held there until it is popped.
// full rises only when the four-entry queue fills while results are not popped.
// Asynchronous active-low reset empties the queue and returns to the opening phase.
// Depends on kfd_pkg, kfd_front, kfd_queue and kfd_back.

module kiss_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       empty,
  input  logic       pop,
  output logic       result_kind_o,
  output logic [7:0] body_byte_o,
  output logic [7:0] frame_type_o,
  output logic       frame_status_o
);

  logic          accept;
  logic          res_valid;
  kfd_pkg::res_t res_front;
  logic          q_valid;
  logic          q_pop;
  kfd_pkg::res_t q_data;
  kfd_pkg::res_t res_out;

  assign accept = push && !full;

  // Byte classification and framing state.
  kfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res_front)
  );

  // Decoupling queue.
  kfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .wdata_i (res_front),
    .pop_i   (q_pop),
    .full_o  (full),
    .valid_o (q_valid),
    .rdata_o (q_data)
  );

  // Output stage.
  kfd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_data_i  (q_data),
    .q_pop_o   (q_pop),
    .pop_i     (pop),
    .empty_o   (empty),
    .res_o     (res_out)
  );

  assign result_kind_o  = res_out.kind;
  assign body_byte_o    = res_out.body;
  assign frame_type_o   = res_out.ftype;
  assign frame_status_o = res_out.status;

endmodule

FILE: tb/sv/kiss_frame_checker.sv
// Checker for the KISS frame decoder: decodes every accepted byte on its own and
// compares each accepted result item with the oldest decoded expectation.
// Depends on kfd_pkg for the byte codes, phase codes and result record.

module kiss_frame_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       empty,
  input  logic       pop,
  input  logic       result_kind_o,
  input  logic [7:0] body_byte_o,
  input  logic [7:0] frame_type_o,
  input  logic       frame_status_o,
  output int         mismatch_count,
  output int         results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  // Decoder state as the checker tracks it.
  logic [2:0] unkiss_phase;
  logic       body_started;
  logic [7:0] frame_type_seen;

  // Results that accepted bytes have caused and that the block still owes.
  kfd_pkg::res_t owed_results[$];
  kfd_pkg::res_t oldest;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
  end

  // Queue one decoded body byte under the current frame type.
  task automatic owe_body_byte(input logic [7:0] value);
    kfd_pkg::res_t rec;
    rec.kind   = kfd_pkg::KindBody;
    rec.body   = value;
    rec.ftype  = frame_type_seen;
    rec.status = kfd_pkg::StatusOk;
    owed_results.push_back(rec);
  endtask

  // Advance the decoder by one received byte.
  task automatic unkiss_byte(input logic [7:0] raw, input logic is_last);
    kfd_pkg::res_t rec;
    if (is_last) begin
      // The flagged byte always closes the buffer with a status item.
      rec.kind   = kfd_pkg::KindStatus;
      rec.body   = 8'h00;
      rec.ftype  = frame_type_seen;
      rec.status = (unkiss_phase == kfd_pkg::PhBody && body_started &&
                    raw == kfd_pkg::Fend) ? kfd_pkg::StatusOk : kfd_pkg::StatusBad;
      owed_results.push_back(rec);
      unkiss_phase    = kfd_pkg::PhOpen;
      body_started    = 1'b0;
      frame_type_seen = 8'h00;
    end else begin
      case (unkiss_phase)
        kfd_pkg::PhOpen: begin
          unkiss_phase = (raw == kfd_pkg::Fend) ? kfd_pkg::PhType : kfd_pkg::PhFault;
        end
        kfd_pkg::PhType: begin
          frame_type_seen = raw;
          body_started    = 1'b0;
          unkiss_phase    = kfd_pkg::PhBody;
        end
        kfd_pkg::PhBody: begin
          if (raw == kfd_pkg::Fend) begin
            unkiss_phase = kfd_pkg::PhFault;
          end else if (raw == kfd_pkg::Fesc) begin
            body_started = 1'b1;
            unkiss_phase = kfd_pkg::PhEsc;
          end else begin
            body_started = 1'b1;
            owe_body_byte(raw);
          end
        end
        kfd_pkg::PhEsc: begin
          if (raw == kfd_pkg::Tfend) begin
            owe_body_byte(kfd_pkg::Fend);
            unkiss_phase = kfd_pkg::PhBody;
          end else if (raw == kfd_pkg::Tfesc) begin
            owe_body_byte(kfd_pkg::Fesc);
            unkiss_phase = kfd_pkg::PhBody;
          end else begin
            unkiss_phase = kfd_pkg::PhFault;
          end
        end
        default: begin
          unkiss_phase = kfd_pkg::PhFault;
        end
      endcase
    end
  endtask

  // Compare one field of a result item and report a difference.
  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Watch both handshakes at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unkiss_phase    = kfd_pkg::PhOpen;
      body_started    = 1'b0;
      frame_type_seen = 8'h00;
      owed_results.delete();
    end else begin
      if (push && !full) begin
        unkiss_byte(data_byte_i, last_byte_i);
      end
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          $display("%0t ns: unexpected result item, expected none, actual %b %h %h %b",
                   $time, result_kind_o, body_byte_o, frame_type_o, frame_status_o);
          mismatch_count++;
        end else begin
          oldest = owed_results.pop_front();
          check_field("result_kind", {7'd0, oldest.kind}, {7'd0, result_kind_o});
          check_field("body_byte", oldest.body, body_byte_o);
          check_field("frame_type", oldest.ftype, frame_type_o);
          check_field("frame_status", {7'd0, oldest.status}, {7'd0, frame_status_o});
        end
      end
    end
    results_due = owed_results.size();
  end

endmodule

FILE: tb/sv/kiss_frame_decoder_tb.sv
// Top of the KISS frame decoder testbench: clock, reset, byte stimulus and verdict.
// Depends on kfd_pkg, the kiss_frame_decoder RTL and kiss_frame_checker.

module kiss_frame_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic       result_kind_o;
  logic [7:0] body_byte_o;
  logic [7:0] frame_type_o;
  logic       frame_status_o;

  int          mismatch_count;
  int          results_due;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned bytes_sent = 0;

  // Bytes of the buffer that is sent next; the final one carries the last flag.
  logic [7:0] kiss_buffer[$];

  kiss_frame_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .body_byte_o    (body_byte_o),
    .frame_type_o   (frame_type_o),
    .frame_status_o (frame_status_o)
  );

  kiss_frame_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .empty          (empty),
    .pop            (pop),
    .result_kind_o  (result_kind_o),
    .body_byte_o    (body_byte_o),
    .frame_type_o   (frame_type_o),
    .frame_status_o (frame_status_o),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // The result side pops at random, regardless of whether an item is waiting.
  always @(negedge clk_i) begin
    pop <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // Offer one byte, idling first at random, and hold it until it is accepted.
  task automatic send_byte(input logic [7:0] raw, input logic is_last);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push        <= 1'b1;
    data_byte_i <= raw;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (full);
    bytes_sent++;
  endtask

  // Send the whole prepared buffer with the last flag on its final byte.
  task automatic send_buffer();
    for (int i = 0; i < kiss_buffer.size(); i++) begin
      send_byte(kiss_buffer[i], i == kiss_buffer.size() - 1);
    end
  endtask

  // Stimulus: directed buffers, then random buffers under three idling schemes.
  initial begin
    int unsigned goal;
    int unsigned pick;
    int unsigned len;
    int unsigned sel;
    int          pos;
    logic [7:0]  payload;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 33;
    recv_idle_pct = 82;

    // A clean frame with both escapes and the extreme byte values.
    kiss_buffer = '{kfd_pkg::Fend, 8'h00, 8'hFF, kfd_pkg::Fesc, kfd_pkg::Tfend,
                    kfd_pkg::Fesc, kfd_pkg::Tfesc, kfd_pkg::Fend};
    send_buffer();
    // A first byte that is not a delimiter.
    kiss_buffer = '{8'h55, kfd_pkg::Fend};
    send_buffer();
    // A buffer that ends on its type byte.
    kiss_buffer = '{kfd_pkg::Fend, 8'h7F};
    send_buffer();
    // A frame with no body at all.
    kiss_buffer = '{kfd_pkg::Fend, 8'hFF, kfd_pkg::Fend};
    send_buffer();
    // A bare delimiter inside the body.
    kiss_buffer = '{kfd_pkg::Fend, 8'h01, kfd_pkg::Fend, kfd_pkg::Fend};
    send_buffer();
    // An escape followed by an ordinary byte.
    kiss_buffer = '{kfd_pkg::Fend, 8'h02, kfd_pkg::Fesc, 8'h41, kfd_pkg::Fend};
    send_buffer();
    // A buffer that closes right after an escape.
    kiss_buffer = '{kfd_pkg::Fend, 8'h03, kfd_pkg::Fesc, kfd_pkg::Fend};
    send_buffer();
    // A good body closed by a wrong final byte.
    kiss_buffer = '{kfd_pkg::Fend, 8'h04, 8'h41, kfd_pkg::Fesc};
    send_buffer();

    for (int scheme = 0; scheme < 3; scheme++) begin
      case (scheme)
        0: begin send_idle_pct = 33; recv_idle_pct = 82; end
        1: begin send_idle_pct = 82; recv_idle_pct = 33; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      goal = bytes_sent + 410;
      while (bytes_sent < goal) begin
        kiss_buffer.delete();
        pick = $urandom_range(99);
        if (pick < 8) begin
          // Line noise with a random closing byte.
          len = $urandom_range(1, 8);
          repeat (len) begin
            sel = $urandom_range(7);
            kiss_buffer.push_back(sel == 0 ? kfd_pkg::Fend :
                                  sel == 1 ? kfd_pkg::Fesc : 8'($urandom));
          end
        end else begin
          // A well-formed frame with a mostly short, escape-rich body.
          kiss_buffer.push_back(kfd_pkg::Fend);
          kiss_buffer.push_back(8'($urandom));
          len = ($urandom_range(15) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
          repeat (len) begin
            sel = $urandom_range(9);
            payload = (sel < 2) ? kfd_pkg::Fend : (sel < 4) ? kfd_pkg::Fesc : 8'($urandom);
            if (payload == kfd_pkg::Fend) begin
              kiss_buffer.push_back(kfd_pkg::Fesc);
              kiss_buffer.push_back(kfd_pkg::Tfend);
            end else if (payload == kfd_pkg::Fesc) begin
              kiss_buffer.push_back(kfd_pkg::Fesc);
              kiss_buffer.push_back(kfd_pkg::Tfesc);
            end else begin
              kiss_buffer.push_back(payload);
            end
          end
          kiss_buffer.push_back(kfd_pkg::Fend);
          // About a quarter of the frames get broken in one place.
          if (pick >= 75) begin
            pos = $urandom_range(2, kiss_buffer.size() - 1);
            case ($urandom_range(5))
              0: kiss_buffer[0] = 8'($urandom);
              1: kiss_buffer.insert(pos, kfd_pkg::Fend);
              2: begin
                kiss_buffer.insert(pos, 8'($urandom));
                kiss_buffer.insert(pos, kfd_pkg::Fesc);
              end
              3: begin
                len = $urandom_range(1, 2);
                while (kiss_buffer.size() > len) void'(kiss_buffer.pop_back());
                if ($urandom_range(1) == 1) kiss_buffer.push_back(kfd_pkg::Fend);
              end
              4: kiss_buffer.insert(kiss_buffer.size() - 1, kfd_pkg::Fesc);
              default: kiss_buffer[kiss_buffer.size() - 1] = 8'($urandom);
            endcase
          end
        end
        send_buffer();
      end
    end

    @(negedge clk_i);
    push <= 1'b0;

    // Drain the owed results, then give the pipeline time to show any extra item.
    while (results_due != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: kiss_frame_decoder.f
hdl/kfd_pkg.sv
hdl/kfd_front.sv
hdl/kfd_queue.sv
hdl/kfd_back.sv
hdl/kiss_frame_decoder.sv
tb/sv/kiss_frame_checker.sv
tb/sv/kiss_frame_decoder_tb.sv
